FILE: src/smc_pkg.sv
package smc_pkg;

    // Table geometry. Slot indexes are ADDR_W bits wide. Probe counters are one bit wider
    // so that they can hold the full table depth.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TABLE_DEPTH - 1);

    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

    // Command codes.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_count;
        logic        table_full;
    } rsp_t;

    // One table entry as it is kept in memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] value;
    } entry_t;

    // Outcome of a probe walk. A walk finds a match, finds an empty slot, or finds neither.
    typedef struct packed {
        logic              found;
        logic              empty;
        logic [ADDR_W-1:0] slot;
    } probe_res_t;

    // Multiplicative hash folded down to a slot index. The folded value stays below
    // twice the depth, so one conditional subtract brings it into range.
    function automatic logic [ADDR_W-1:0] home_slot(input logic [31:0] v);
        logic [31:0]      prod;
        logic [31:0]      h;
        logic [CNT_W-1:0] low;
        prod = v * HASH_MULT;
        h    = prod ^ (prod >> 16);
        low  = {1'b0, h[ADDR_W-1:0]};
        if (low >= DEPTH_CNT)
        begin
            low = low - DEPTH_CNT;
        end
        return low[ADDR_W-1:0];
    endfunction

endpackage

FILE: src/smc_ram.sv
module smc_ram #(
    parameter int DATA_W = 33,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/smc_probe.sv
module smc_probe (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           key,
    output logic                  rd_en,
    output logic [smc_pkg::ADDR_W-1:0] rd_addr,
    input  smc_pkg::entry_t       rd_data,
    output logic                  done,
    output smc_pkg::probe_res_t   res
);
    import smc_pkg::*;

    // Reads are issued one slot per cycle. Each read returns in the next cycle and is checked
    // then, so the walk streams through the table at one entry per cycle.
    logic              busy_reg,      busy_next;
    logic [ADDR_W-1:0] iss_addr_reg,  iss_addr_next;
    logic [CNT_W-1:0]  iss_cnt_reg,   iss_cnt_next;
    logic [CNT_W-1:0]  chk_cnt_reg,   chk_cnt_next;
    logic              pend_reg,      pend_next;
    logic [ADDR_W-1:0] pend_slot_reg, pend_slot_next;
    logic [31:0]       key_reg,       key_next;
    logic              issue;

    always_comb
    begin
        busy_next      = busy_reg;
        iss_addr_next  = iss_addr_reg;
        iss_cnt_next   = iss_cnt_reg;
        chk_cnt_next   = chk_cnt_reg;
        key_next       = key_reg;
        pend_slot_next = iss_addr_reg;
        done           = 1'b0;
        res            = '{found: 1'b0, empty: 1'b0, slot: pend_slot_reg};

        if (busy_reg && pend_reg)
        begin
            if (!rd_data.valid)
            begin
                done      = 1'b1;
                res.empty = 1'b1;
            end
            else if (rd_data.value == key_reg)
            begin
                done      = 1'b1;
                res.found = 1'b1;
            end
            else if (chk_cnt_reg == LAST_CNT)
            begin
                // Every slot has been seen without a match or a hole.
                done = 1'b1;
            end
            else
            begin
                chk_cnt_next = chk_cnt_reg + 1'b1;
            end
        end

        issue = busy_reg && !done && (iss_cnt_reg != DEPTH_CNT);
        if (issue)
        begin
            iss_cnt_next  = iss_cnt_reg + 1'b1;
            iss_addr_next = (iss_addr_reg == LAST_SLOT) ? '0 : iss_addr_reg + 1'b1;
        end
        pend_next = issue;

        if (done)
        begin
            busy_next = 1'b0;
        end

        if (start)
        begin
            busy_next     = 1'b1;
            iss_addr_next = home_slot(key);
            iss_cnt_next  = '0;
            chk_cnt_next  = '0;
            pend_next     = 1'b0;
            key_next      = key;
        end
    end

    assign rd_en   = issue;
    assign rd_addr = iss_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_addr_reg  <= iss_addr_next;
        iss_cnt_reg   <= iss_cnt_next;
        chk_cnt_reg   <= chk_cnt_next;
        pend_slot_reg <= pend_slot_next;
        key_reg       <= key_next;
    end

endmodule

FILE: src/set_membership_counter.sv
// Channel | Handshake             | Word                              | Accepted when
// req     | req_valid / req_ready | req  (cmd, value)                 | req_valid && req_ready
// rsp     | rsp_valid / rsp_ready | rsp  (hit, hit_count, table_full) | rsp_valid && rsp_ready
//
// Insert and query walk the table from the home slot of the value until a slot settles the
// probe, and at most TABLE_DEPTH slots are walked.
// The walk is paced by the single read port of the table memory.
// Clear writes every slot once and then responds. An unused command responds without a
// walk or a table write.
// After reset the same sweep runs with req_ready low.
// A finished response waits in the output register while the next command is accepted.
module set_membership_counter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  smc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output smc_pkg::rsp_t rsp
);
    import smc_pkg::*;

    // The controller has four states:
    //   ST_SWEEP  clears the table, one slot per cycle.
    //   ST_IDLE   waits for a command.
    //   ST_PROBE  waits for the probe engine to finish its walk.
    //   ST_RESP   waits until the output register is free.
    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_PROBE,
        ST_RESP
    } state_t;

    state_t            state_reg,      state_next;
    logic [1:0]        cmd_reg,        cmd_next;
    logic [31:0]       value_reg,      value_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic              sweep_rsp_reg,  sweep_rsp_next;
    logic [31:0]       count_reg,      count_next;
    logic              hit_reg,        hit_next;
    logic              full_reg,       full_next;
    logic              rsp_valid_reg,  rsp_valid_next;
    rsp_t              rsp_reg,        rsp_next;

    // Table memory ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;

    // Probe engine interface.
    logic       probe_start;
    logic       probe_done;
    probe_res_t probe_res;

    smc_ram #(
        .DATA_W ($bits(entry_t)),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    smc_probe u_probe (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (probe_start),
        .key     (req.value),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata),
        .done    (probe_done),
        .res     (probe_res)
    );

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_rsp_next  = sweep_rsp_reg;
        count_next      = count_reg;
        hit_next        = hit_reg;
        full_next       = full_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        probe_start     = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = sweep_addr_reg;
        ram_wdata       = '{valid: 1'b0, value: 32'd0};

        case (state_reg)
            ST_SWEEP:
            begin
                // Every slot is written with its valid mark cleared.
                ram_we = 1'b1;
                if (sweep_addr_reg == LAST_SLOT)
                begin
                    hit_next   = 1'b0;
                    full_next  = 1'b0;
                    state_next = sweep_rsp_reg ? ST_RESP : ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.cmd;
                    value_next = req.value;
                    case (req.cmd)
                        CMD_CLEAR:
                        begin
                            count_next      = '0;
                            sweep_addr_next = '0;
                            sweep_rsp_next  = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                        CMD_INSERT, CMD_QUERY:
                        begin
                            probe_start = 1'b1;
                            state_next  = ST_PROBE;
                        end
                        default:
                        begin
                            // An unused code leaves the state alone and reports no hit.
                            hit_next   = 1'b0;
                            full_next  = 1'b0;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_PROBE:
            begin
                if (probe_done)
                begin
                    hit_next  = (cmd_reg == CMD_QUERY) && probe_res.found;
                    full_next = (cmd_reg == CMD_INSERT) && !probe_res.found
                                && !probe_res.empty;
                    if ((cmd_reg == CMD_INSERT) && probe_res.empty)
                    begin
                        // A new value goes into the first hole on its probe path.
                        ram_we    = 1'b1;
                        ram_waddr = probe_res.slot;
                        ram_wdata = '{valid: 1'b1, value: value_reg};
                    end
                    if ((cmd_reg == CMD_QUERY) && probe_res.found && (count_reg != '1))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{hit: hit_reg, hit_count: count_reg,
                                       table_full: full_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            sweep_rsp_reg  <= 1'b0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            cmd_reg        <= CMD_CLEAR;
            value_reg      <= '0;
            hit_reg        <= 1'b0;
            full_reg       <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_rsp_reg  <= sweep_rsp_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
            cmd_reg        <= cmd_next;
            value_reg      <= value_next;
            hit_reg        <= hit_next;
            full_reg       <= full_next;
            rsp_reg        <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The probe engine reports a result only while the controller waits for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        probe_done |-> (state_reg == ST_PROBE))
        else $error("probe finished outside the probe state");

    // Outside the sweep, the table is written only into a hole that a probe has just found.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg != ST_SWEEP)) |-> (probe_done && probe_res.empty
                                                 && (cmd_reg == CMD_INSERT)))
        else $error("table write without an empty slot from the probe");

    // Once saturated, the hit counter changes only through a clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '1) |=> ((count_reg == '1) || (count_reg == '0)))
        else $error("hit counter left saturation without a clear");

    // While the sweep runs, no command is taken and no probe starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (!req_ready && !probe_start && !ram_re))
        else $error("activity during the clearing sweep");

endmodule
